[rtl/core/tdp_pkg.sv]
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared constants for the trial-division prime test.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int FIRST_DIVISOR  = 2;

endpackage

[rtl/core/tdp_in_if.sv]
// ----------------------------------------------------------------------------
// tdp_in_if
// Candidate channel: valid/ready handshake carrying one candidate per item.
// ----------------------------------------------------------------------------
interface tdp_in_if #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

[rtl/core/tdp_out_if.sv]
// ----------------------------------------------------------------------------
// tdp_out_if
// Result channel: valid/ready handshake carrying the tested value and flag.
// ----------------------------------------------------------------------------
interface tdp_out_if #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] tested_value;
    logic                  is_prime;

    modport source (output valid, output tested_value, output is_prime, input ready);
    modport sink   (input valid, input tested_value, input is_prime, output ready);
endinterface

[rtl/core/tdp_rem.sv]
// ----------------------------------------------------------------------------
// tdp_rem
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tdp_rem #(
    parameter int WIDTH = tdp_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic             rem_zero
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg,   rem_next;
    logic [WIDTH-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             done_reg,  done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    assign trial = {rem_reg, shift_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            shift_next = dividend;
            cnt_next   = CNT_W'(WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            // remainder always stays below the divisor, so it fits WIDTH bits
            if (trial >= {1'b0, divisor})
                rem_next = diff[WIDTH-1:0];
            else
                rem_next = trial[WIDTH-1:0];
            shift_next = {shift_reg[WIDTH-2:0], 1'b0};
            cnt_next   = cnt_reg - CNT_W'(1);
            done_next  = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);
endmodule

[rtl/core/tdp_divgen.sv]
// ----------------------------------------------------------------------------
// tdp_divgen
// Trial divisor stepper: tracks d and d*d, updating the square by 2d+1.
// ----------------------------------------------------------------------------
module tdp_divgen #(
    parameter int WIDTH = tdp_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             init,
    input  logic             step,
    output logic [WIDTH-1:0] divisor,
    output logic [WIDTH:0]   square
);
    import tdp_pkg::*;

    logic [WIDTH-1:0] d_reg,  d_next;
    logic [WIDTH:0]   sq_reg, sq_next;

    always_comb
    begin
        d_next  = d_reg;
        sq_next = sq_reg;
        if (init)
        begin
            d_next  = WIDTH'(FIRST_DIVISOR);
            sq_next = (WIDTH+1)'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
        else if (step)
        begin
            // (d+1)^2 = d^2 + 2d + 1; stepping stops once the square passes n
            sq_next = sq_reg + {d_reg, 1'b1};
            d_next  = d_reg + WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg  <= d_next;
        sq_reg <= sq_next;
    end

    assign divisor = d_reg;
    assign square  = sq_reg;
endmodule

[rtl/core/trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
//   channel   dir   payload                     handshake
//   in_ch     in    candidate                   valid & ready
//   out_ch    out   tested_value, is_prime      valid & ready
//
// One item at a time. Each divisor tried (from 2 up to sqrt(n), so up to
// sqrt(n)-1 of them) goes through the serial remainder unit, one bit a
// cycle. Reset clears the sequencer and output valid. A result waits in its
// output register while the next candidate is taken in.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tdp_in_if.sink    in_ch,
    tdp_out_if.source out_ch
);
    import tdp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic                  prime_reg, prime_next;
    logic                  ovalid_reg, ovalid_next;
    logic [VALUE_BITS-1:0] oval_reg, oval_next;
    logic                  oprime_reg, oprime_next;

    logic                  gen_init, gen_step, rem_start, rem_done, rem_zero;
    logic [VALUE_BITS-1:0] divisor;
    logic [VALUE_BITS:0]   square;

    tdp_divgen #(.WIDTH(VALUE_BITS)) u_divgen (
        .clk     (clk),
        .init    (gen_init),
        .step    (gen_step),
        .divisor (divisor),
        .square  (square)
    );

    tdp_rem #(.WIDTH(VALUE_BITS)) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (n_reg),
        .divisor  (divisor),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        prime_next  = prime_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        oprime_next = oprime_reg;
        gen_init    = 1'b0;
        gen_step    = 1'b0;
        rem_start   = 1'b0;

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    n_next     = in_ch.candidate;
                    gen_init   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (n_reg < VALUE_BITS'(FIRST_DIVISOR))
                begin
                    prime_next = 1'b0;
                    state_next = S_FINISH;
                end
                else if (square > {1'b0, n_reg})
                begin
                    prime_next = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_done)
                begin
                    if (rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        gen_step   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_FINISH:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    oval_next   = n_reg;
                    oprime_next = prime_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        prime_reg  <= prime_next;
        oval_reg   <= oval_next;
        oprime_reg <= oprime_next;
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.tested_value = oval_reg;
    assign out_ch.is_prime     = oprime_reg;
endmodule
